// ===== src/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/stsp_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types.
// No dependencies; imported by every module of the slack pass block.
package stsp_pkg;

   localparam int TIME_W     = 48;
   localparam int DLY_W      = 32;
   localparam int IDEP_W     = 11;
   localparam int ODEP_W     = 10;
   localparam int NODE_FLD_W = 10;
   localparam int TARGET_W   = 46;
   localparam int OP_W       = 3;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 120;

   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_FANIN  = 3'd1;
   localparam logic [OP_W-1:0] OP_FANOUT = 3'd2;
   localparam logic [OP_W-1:0] OP_RUN    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   localparam logic [STAT_W-1:0] ST_ACCEPT   = 2'd0;
   localparam logic [STAT_W-1:0] ST_RUN_DONE = 2'd1;
   localparam logic [STAT_W-1:0] ST_READ     = 2'd2;
   localparam logic [STAT_W-1:0] ST_REJECT   = 2'd3;

   typedef struct packed {
      logic              take;        // latch owner and neighbor
      logic              load_node;
      logic              clear_graph;
      logic              sel_out;     // 1: fanout list, 0: fanin list
      logic              gap_write;   // start[fill] <= count, fill++
      logic              list_write;  // list[count] <= neighbor, count++
      logic              read_issue;
      logic              rsp_load;
      logic [STAT_W-1:0] rsp_kind;
      logic              fwd_init;
      logic              fstart;
      logic              fseg;
      logic              flist;
      logic              fnode;
      logic              facc;
      logic              fwrite;
      logic              bwd_init;
      logic              bhi;
      logic              bstart;
      logic              bseg;
      logic              blist;
      logic              bnode;
      logic              bacc;
      logic              bwrite;
      logic              set_valid;
   } cmd_type;

   typedef struct packed {
      logic ok_load;
      logic ok_fanin;
      logic ok_fanout;
      logic ok_read;
      logic gap_done;
      logic close_done;
      logic graph_empty;
      logic edges_left;
      logic fwd_last;
      logic bwd_last;
   } stat_type;

endpackage

// ===== src/stsp_datapath.sv =====
// Datapath: graph memories, fill counters, pass accumulators and response register.
// Depends on stsp_pkg; driven by stsp_ctrl through cmd_type / stat_type.
module stsp_datapath
   import stsp_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic [NODE_FLD_W-1:0]        req_node,
   input  logic [NODE_FLD_W-1:0]        req_nb,
   input  logic [DLY_W-1:0]             req_delay,
   input  logic [TARGET_W-1:0]          target,
   output logic [STAT_W-1:0]            rsp_status,
   output logic [RSP_DATA_W-1:0]        rsp_data
);

   localparam int AW  = $clog2(MAX_NODES);
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);

   logic [DLY_W-1:0]         delay_mem     [MAX_NODES];
   logic [ECW-1:0]           fin_start_mem [MAX_NODES+1];
   logic [ECW-1:0]           fout_start_mem[MAX_NODES+1];
   logic [AW-1:0]            fin_list_mem  [MAX_EDGES];
   logic [AW-1:0]            fout_list_mem [MAX_EDGES];
   logic signed [TIME_W-1:0] arr_mem       [MAX_NODES];
   logic signed [TIME_W-1:0] req_mem       [MAX_NODES];
   logic [IDEP_W-1:0]        idep_mem      [MAX_NODES];
   logic [ODEP_W-1:0]        odep_mem      [MAX_NODES];

   logic [DLY_W-1:0]         dly_rd_ff;
   logic [ECW-1:0]           fin_start_rd_ff, fout_start_rd_ff;
   logic [AW-1:0]            fin_list_rd_ff, fout_list_rd_ff;
   logic signed [TIME_W-1:0] arr_rd_ff, req_rd_ff;
   logic [IDEP_W-1:0]        idep_rd_ff;
   logic [ODEP_W-1:0]        odep_rd_ff;

   logic [CW-1:0]  node_count_ff, fin_fill_ff, fout_fill_ff;
   logic [ECW-1:0] fin_count_ff, fout_count_ff;
   logic           results_valid_ff;

   logic [NODE_FLD_W-1:0]    node_ff, nb_ff;
   logic [CW-1:0]            i_ff;
   logic [ECW-1:0]           e_ff, end_ff, lo_ff;
   logic [DLY_W-1:0]         dly_ff;
   logic                     vld_ff;
   logic signed [TIME_W-1:0] a_ff, r_ff;
   logic [IDEP_W-1:0]        d_ff;
   logic [ODEP_W-1:0]        od_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   logic [AW-1:0]            dly_raddr, arr_raddr, req_raddr, node_idx, i_idx;
   logic [CW-1:0]            fout_start_raddr;
   logic signed [TIME_W-1:0] slack_v, target_s;
   logic [ODEP_W-1:0]        od_cand;
   logic                     order_in, order_out;

   assign node_idx  = AW'(req_node);
   assign i_idx     = i_ff[AW-1:0];
   assign dly_raddr = cmd.fstart ? i_idx : fout_list_rd_ff;
   assign arr_raddr = cmd.fnode ? fin_list_rd_ff : node_idx;
   assign req_raddr = cmd.bnode ? fout_list_rd_ff : node_idx;
   assign fout_start_raddr = cmd.bwd_init ? node_count_ff : CW'(i_ff - 1'b1);
   assign slack_v   = req_rd_ff - signed'({16'b0, dly_rd_ff});
   assign target_s  = signed'({2'b0, target});
   assign od_cand   = odep_rd_ff + 1'b1;

   // An owner may repeat the previous one but never go below it.
   assign order_in  = !(fin_fill_ff != '0 && 32'(req_node) + 1 < 32'(fin_fill_ff));
   assign order_out = !(fout_fill_ff != '0 && 32'(req_node) + 1 < 32'(fout_fill_ff));

   always_comb begin
      stat.ok_load = 32'(req_node) == 32'(node_count_ff) && 32'(node_count_ff) < MAX_NODES &&
                     fin_count_ff == '0 && fout_count_ff == '0 &&
                     fin_fill_ff == '0 && fout_fill_ff == '0;
      stat.ok_fanin = 32'(req_node) < 32'(node_count_ff) && req_nb < req_node &&
                      32'(fin_count_ff) < MAX_EDGES && order_in;
      stat.ok_fanout = 32'(req_node) < 32'(node_count_ff) && req_nb > req_node &&
                       32'(req_nb) < 32'(node_count_ff) &&
                       32'(fout_count_ff) < MAX_EDGES && order_out;
      stat.ok_read = results_valid_ff && 32'(req_node) < 32'(node_count_ff);
      stat.gap_done = cmd.sel_out ? 32'(fout_fill_ff) > 32'(node_ff)
                                  : 32'(fin_fill_ff) > 32'(node_ff);
      stat.close_done = cmd.sel_out ? fout_fill_ff > node_count_ff
                                    : fin_fill_ff > node_count_ff;
      stat.graph_empty = node_count_ff == '0;
      stat.edges_left  = e_ff < end_ff;
      stat.fwd_last    = 32'(i_ff) + 1 == 32'(node_count_ff);
      stat.bwd_last    = i_ff == '0;
   end

   // memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cmd.load_node) begin
         delay_mem[node_idx] <= req_delay;
      end
      if (cmd.gap_write && !cmd.sel_out) begin
         fin_start_mem[fin_fill_ff] <= fin_count_ff;
      end
      if (cmd.gap_write && cmd.sel_out) begin
         fout_start_mem[fout_fill_ff] <= fout_count_ff;
      end
      if (cmd.list_write && !cmd.sel_out) begin
         fin_list_mem[fin_count_ff[EAW-1:0]] <= AW'(nb_ff);
      end
      if (cmd.list_write && cmd.sel_out) begin
         fout_list_mem[fout_count_ff[EAW-1:0]] <= AW'(nb_ff);
      end
      if (cmd.fwrite) begin
         arr_mem[i_idx]  <= a_ff + signed'({16'b0, dly_ff});
         idep_mem[i_idx] <= d_ff + 1'b1;
      end
      if (cmd.bwrite) begin
         req_mem[i_idx]  <= r_ff;
         odep_mem[i_idx] <= od_ff;
      end
      dly_rd_ff        <= delay_mem[dly_raddr];
      fin_start_rd_ff  <= fin_start_mem[CW'(i_ff + 1'b1)];
      fout_start_rd_ff <= fout_start_mem[fout_start_raddr];
      if (cmd.flist) fin_list_rd_ff <= fin_list_mem[e_ff[EAW-1:0]];
      if (cmd.blist) fout_list_rd_ff <= fout_list_mem[e_ff[EAW-1:0]];
      if (cmd.read_issue || cmd.fnode) begin
         arr_rd_ff  <= arr_mem[arr_raddr];
         idep_rd_ff <= idep_mem[arr_raddr];
      end
      if (cmd.read_issue || cmd.bnode) begin
         req_rd_ff  <= req_mem[req_raddr];
         odep_rd_ff <= odep_mem[req_raddr];
      end
   end

   // graph fill state
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_graph) begin
         node_count_ff    <= '0;
         fin_fill_ff      <= '0;
         fout_fill_ff     <= '0;
         fin_count_ff     <= '0;
         fout_count_ff    <= '0;
         results_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_node) node_count_ff <= node_count_ff + 1'b1;
         if (cmd.gap_write && !cmd.sel_out) fin_fill_ff <= fin_fill_ff + 1'b1;
         if (cmd.gap_write && cmd.sel_out) fout_fill_ff <= fout_fill_ff + 1'b1;
         if (cmd.list_write && !cmd.sel_out) fin_count_ff <= fin_count_ff + 1'b1;
         if (cmd.list_write && cmd.sel_out) fout_count_ff <= fout_count_ff + 1'b1;
         if (cmd.set_valid) results_valid_ff <= 1'b1;
      end
   end

   // pass sequencing and accumulation
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         node_ff <= req_node;
         nb_ff   <= req_nb;
      end
      if (cmd.fwd_init) i_ff <= '0;
      else if (cmd.fwrite) i_ff <= i_ff + 1'b1;
      else if (cmd.bwd_init) i_ff <= node_count_ff;
      else if (cmd.bstart) i_ff <= i_ff - 1'b1;

      if (cmd.fwd_init) e_ff <= '0;
      else if (cmd.bseg) e_ff <= fout_start_rd_ff;
      else if (cmd.fnode || cmd.bnode) e_ff <= e_ff + 1'b1;

      if (cmd.fseg) end_ff <= fin_start_rd_ff;
      else if (cmd.bhi) end_ff <= fout_start_rd_ff;
      else if (cmd.bwrite) end_ff <= lo_ff;  // this node's low bound is the next node's high
      if (cmd.bseg) lo_ff <= fout_start_rd_ff;

      if (cmd.fnode) vld_ff <= 32'(fin_list_rd_ff) < 32'(i_ff);
      else if (cmd.bnode) vld_ff <= 32'(fout_list_rd_ff) > 32'(i_ff) &&
                                    32'(fout_list_rd_ff) < 32'(node_count_ff);

      if (cmd.fseg) begin
         dly_ff <= dly_rd_ff;
         a_ff   <= '0;
         d_ff   <= '0;
      end else if (cmd.facc && vld_ff) begin
         if (arr_rd_ff > a_ff) a_ff <= arr_rd_ff;
         if (idep_rd_ff > d_ff) d_ff <= idep_rd_ff;
      end

      if (cmd.bseg) begin
         r_ff  <= target_s;
         od_ff <= '0;
      end else if (cmd.bacc && vld_ff) begin
         if (slack_v < r_ff) r_ff <= slack_v;
         if (od_cand > od_ff) od_ff <= od_cand;
      end

      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_kind;
         if (cmd.rsp_kind == ST_READ) begin
            rsp_data_ff <= {3'b0, odep_rd_ff, idep_rd_ff, req_rd_ff, arr_rd_ff};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== src/stsp_ctrl.sv =====
// Controller FSM: handshakes, item decode, edge gap fill, list close and both passes.
// Depends on stsp_pkg; commands stsp_datapath.
module stsp_ctrl
   import stsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output cmd_type         cmd,
   input  stat_type        stat
);

   typedef enum logic [4:0] {
      S_IDLE, S_EDGE_GAP, S_READ_WAIT, S_CLOSE_IN, S_CLOSE_OUT,
      S_F_START, S_F_SEG, S_F_EDGE, S_F_FETCH, S_F_ACC, S_F_WRITE,
      S_B_INIT, S_B_HI, S_B_START, S_B_SEG, S_B_EDGE, S_B_FETCH, S_B_ACC, S_B_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      sel_ff, sel_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd.sel_out = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.take     = 1'b1;
               cmd.rsp_kind = ST_REJECT;
               unique case (req_op) inside
                  OP_LOAD: begin
                     cmd.load_node = stat.ok_load;
                     cmd.rsp_load  = 1'b1;
                     cmd.rsp_kind  = stat.ok_load ? ST_ACCEPT : ST_REJECT;
                  end
                  OP_FANIN, OP_FANOUT: begin
                     sel_in      = req_op == OP_FANOUT;
                     cmd.sel_out = sel_in;
                     if (sel_in ? stat.ok_fanout : stat.ok_fanin) begin
                        state_in = S_EDGE_GAP;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     sel_in   = 1'b0;
                     state_in = S_CLOSE_IN;
                  end
                  OP_READ: begin
                     if (stat.ok_read) begin
                        cmd.read_issue = 1'b1;
                        state_in       = S_READ_WAIT;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear_graph = 1'b1;
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_kind    = ST_ACCEPT;
                  end
                  default: cmd.rsp_load = 1'b1;
               endcase
            end
         end
         S_EDGE_GAP: begin
            if (stat.gap_done) begin
               cmd.list_write = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = ST_ACCEPT;
               state_in       = S_IDLE;
            end else begin
               cmd.gap_write = 1'b1;
            end
         end
         S_READ_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = ST_READ;
            state_in     = S_IDLE;
         end
         S_CLOSE_IN: begin
            if (stat.close_done) begin
               sel_in   = 1'b1;
               state_in = S_CLOSE_OUT;
            end else begin
               cmd.gap_write = 1'b1;
            end
         end
         S_CLOSE_OUT: begin
            if (!stat.close_done) begin
               cmd.gap_write = 1'b1;
            end else if (stat.graph_empty) begin
               cmd.set_valid = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_kind  = ST_RUN_DONE;
               state_in      = S_IDLE;
            end else begin
               cmd.fwd_init = 1'b1;
               state_in     = S_F_START;
            end
         end
         S_F_START: begin
            cmd.fstart = 1'b1;
            state_in   = S_F_SEG;
         end
         S_F_SEG: begin
            cmd.fseg = 1'b1;
            state_in = S_F_EDGE;
         end
         S_F_EDGE: begin
            if (stat.edges_left) begin
               cmd.flist = 1'b1;
               state_in  = S_F_FETCH;
            end else begin
               state_in = S_F_WRITE;
            end
         end
         S_F_FETCH: begin
            cmd.fnode = 1'b1;
            state_in  = S_F_ACC;
         end
         S_F_ACC: begin
            cmd.facc = 1'b1;
            state_in = S_F_EDGE;
         end
         S_F_WRITE: begin
            cmd.fwrite = 1'b1;
            state_in   = stat.fwd_last ? S_B_INIT : S_F_START;
         end
         S_B_INIT: begin
            cmd.bwd_init = 1'b1;
            state_in     = S_B_HI;
         end
         S_B_HI: begin
            cmd.bhi  = 1'b1;
            state_in = S_B_START;
         end
         S_B_START: begin
            cmd.bstart = 1'b1;
            state_in   = S_B_SEG;
         end
         S_B_SEG: begin
            cmd.bseg = 1'b1;
            state_in = S_B_EDGE;
         end
         S_B_EDGE: begin
            if (stat.edges_left) begin
               cmd.blist = 1'b1;
               state_in  = S_B_FETCH;
            end else begin
               state_in = S_B_WRITE;
            end
         end
         S_B_FETCH: begin
            cmd.bnode = 1'b1;
            state_in  = S_B_ACC;
         end
         S_B_ACC: begin
            cmd.bacc = 1'b1;
            state_in = S_B_EDGE;
         end
         S_B_WRITE: begin
            cmd.bwrite = 1'b1;
            if (stat.bwd_last) begin
               cmd.set_valid = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_kind  = ST_RUN_DONE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_B_START;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

endmodule

// ===== src/static_timing_slack_pass.sv =====
// Static timing slack pass over a loaded, topologically ordered gate graph.
// Items arrive on req_* (op in req_tuser); one response per item leaves on rsp_*
// with its status in rsp_tuser. Depends on stsp_pkg, stsp_ctrl, stsp_datapath.
//
// Usage: load node delays in node order, then fanin and fanout edges grouped by
// ascending owner, then a run item, then read items. Clear empties the graph.
// csr_wr_en/csr_wr_data set the target cycle time at any clock while idle.
// Load, clear and rejected items load the response register when accepted;
// a read first fetches the node's results; an edge first fills in one missing
// list start per step up to its owner. A run fills in the remaining list starts,
// then walks every node forward and then backward, with a list read, a fetch and
// an accumulate step per fanin or fanout edge; memory read data is registered.
// One item is in work at a time; req_tready rises again once the response
// register is free or being taken, so a stalled rsp_tready holds off input.
// Reset empties the graph, drops pending results and zeros the target; the
// node and edge memories are not swept and hold stale data until rewritten.
`include "assert_macros.svh"
module static_timing_slack_pass
   import stsp_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // node[9:0], neighbor[19:10], delay[51:20]
   input  logic [OP_W-1:0]         req_tuser,   // op[2:0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // arrival[47:0], required[95:48],
                                                // depth_from_inputs[106:96],
                                                // depth_to_outputs[116:107]
   output logic [STAT_W-1:0]       rsp_tuser,   // status[1:0]
   input  logic                    csr_wr_en,
   input  logic [TARGET_W-1:0]     csr_wr_data
);

   cmd_type               cmd;
   stat_type              stat;
   logic [TARGET_W-1:0]   required_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         required_time_ff <= '0;
      end else if (csr_wr_en) begin
         required_time_ff <= csr_wr_data;
      end
   end

   stsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   stsp_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_node   (req_tdata[9:0]),
      .req_nb     (req_tdata[19:10]),
      .req_delay  (req_tdata[51:20]),
      .target     (required_time_ff),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_tdata)
   );

   `ASSERT_IMPLIES(a_accept_needs_free_rsp, req_tvalid && req_tready,
      !rsp_tvalid || rsp_tready, "input transfer while response register is held")
   `ASSERT_IMPLIES(a_data_zero_unless_read, rsp_tvalid && rsp_tuser != ST_READ,
      rsp_tdata == '0, "nonzero response data on a non-read status")
   `ASSERT_NEXT(a_clear_answers_next, req_tvalid && req_tready && req_tuser == OP_CLEAR,
      rsp_tvalid && rsp_tuser == ST_ACCEPT, "clear not answered in the next cycle")

endmodule
